@@ src/dlmv_pkg.sv @@
// ----------------------------------------------------------------------------
// dlmv_pkg: shared types and constants of the dense layer
// Default sizes, accumulator width, operation codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dlmv_pkg;

	localparam int IN_COUNT_DEF   = 16;
	localparam int OUT_COUNT_DEF  = 32;
	localparam int VALUE_BITS_DEF = 16;
	localparam int ACC_BITS       = 40;
	localparam int BIAS_SHIFT     = 8;

	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_DATA   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2
	} state_t;

	typedef struct packed {
		logic load_weight;
		logic load_bias;
		logic capture;
		logic issue;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
	} sts_t;

	function automatic int idx_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

@@ src/dense_layer_matvec_bias.sv @@
// ----------------------------------------------------------------------------
// dense_layer_matvec_bias: fully connected layer with bias
// Command channel: an item transfers at a clock edge with start high and busy
// low. op selects a weight write, a bias write or one data element.
// Weight and bias writes leave busy low. A data element raises busy while
// one shared multiply-accumulate unit walks the outputs, one per cycle,
// through a RAM read, a multiply and an add with write-back into the
// accumulator RAM, and while its pipeline drains. The next item may
// transfer only once busy is low again after a data element.
// The first element of a vector loads each accumulator with its bias
// shifted left by BIAS_SHIFT. On the element marked vector_end the sums
// leave in output order, one per cycle, each shown for one cycle with
// result_strobe high; the first follows the read, multiply-add and result
// registers after the element's transfer. The receiver cannot stall.
// Reset clears the controller and closes any open vector; weight and bias
// RAMs hold no reset value and must be written before they are read.
// ----------------------------------------------------------------------------
module dense_layer_matvec_bias #(
	parameter int IN_COUNT   = dlmv_pkg::IN_COUNT_DEF,
	parameter int OUT_COUNT  = dlmv_pkg::OUT_COUNT_DEF,
	parameter int VALUE_BITS = dlmv_pkg::VALUE_BITS_DEF,
	localparam int WIDX_BITS = dlmv_pkg::idx_bits(IN_COUNT * OUT_COUNT),
	localparam int OIDX_BITS = dlmv_pkg::idx_bits(OUT_COUNT),
	localparam int IIDX_BITS = dlmv_pkg::idx_bits(IN_COUNT)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           op,
	input  logic [WIDX_BITS-1:0]                 weight_index,
	input  logic [OIDX_BITS-1:0]                 bias_index,
	input  logic [IIDX_BITS-1:0]                 input_index,
	input  logic signed [VALUE_BITS-1:0]         operand_value,
	input  logic                                 vector_end,
	output logic                                 result_strobe,
	output logic [OIDX_BITS-1:0]                 output_index,
	output logic signed [dlmv_pkg::ACC_BITS-1:0] output_value,
	output logic                                 output_last
);
	import dlmv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dlmv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	dlmv_dp #(
		.IN_COUNT   (IN_COUNT),
		.OUT_COUNT  (OUT_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.weight_index  (weight_index),
		.bias_index    (bias_index),
		.input_index   (input_index),
		.operand_value (operand_value),
		.vector_end    (vector_end),
		.result_strobe (result_strobe),
		.output_index  (output_index),
		.output_value  (output_value),
		.output_last   (output_last)
	);

endmodule

@@ src/dlmv_ram.sv @@
// ----------------------------------------------------------------------------
// dlmv_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dlmv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = dlmv_pkg::idx_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import dlmv_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/dlmv_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlmv_ctrl: sequencer of the dense layer
// Accepts commands, steps the datapath through one pass over all outputs
// per data element and waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module dlmv_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     op,
	input  dlmv_pkg::sts_t sts,
	output logic           busy,
	output dlmv_pkg::cmd_t cmd
);
	import dlmv_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (op_t'(op))
						OP_WEIGHT: cmd.load_weight = 1'b1;
						OP_BIAS:   cmd.load_bias = 1'b1;
						OP_DATA: begin
							cmd.capture = 1'b1;
							state_d     = ST_RUN;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

endmodule

@@ src/dlmv_dp.sv @@
// ----------------------------------------------------------------------------
// dlmv_dp: datapath of the dense layer
// Weight, bias and accumulator RAMs and one shared multiply-accumulate
// pipeline: read, multiply, add and write back, with the result register.
// ----------------------------------------------------------------------------
module dlmv_dp #(
	parameter int IN_COUNT   = dlmv_pkg::IN_COUNT_DEF,
	parameter int OUT_COUNT  = dlmv_pkg::OUT_COUNT_DEF,
	parameter int VALUE_BITS = dlmv_pkg::VALUE_BITS_DEF,
	localparam int WIDX_BITS = dlmv_pkg::idx_bits(IN_COUNT * OUT_COUNT),
	localparam int OIDX_BITS = dlmv_pkg::idx_bits(OUT_COUNT),
	localparam int IIDX_BITS = dlmv_pkg::idx_bits(IN_COUNT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dlmv_pkg::cmd_t                      cmd,
	output dlmv_pkg::sts_t                      sts,
	input  logic [WIDX_BITS-1:0]                weight_index,
	input  logic [OIDX_BITS-1:0]                bias_index,
	input  logic [IIDX_BITS-1:0]                input_index,
	input  logic signed [VALUE_BITS-1:0]        operand_value,
	input  logic                                vector_end,
	output logic                                result_strobe,
	output logic [OIDX_BITS-1:0]                output_index,
	output logic signed [dlmv_pkg::ACC_BITS-1:0] output_value,
	output logic                                output_last
);
	import dlmv_pkg::*;

	localparam int WDEPTH    = IN_COUNT * OUT_COUNT;
	localparam int PROD_BITS = 2 * VALUE_BITS;

	logic                         weight_we;
	logic                         bias_we;
	logic [WIDX_BITS-1:0]         weight_raddr;
	logic [VALUE_BITS-1:0]        weight_rd;
	logic [VALUE_BITS-1:0]        bias_rd;
	logic [ACC_BITS-1:0]          acc_rd;
	logic [ACC_BITS-1:0]          sum;

	logic signed [VALUE_BITS-1:0] value_q;
	logic [WIDX_BITS-1:0]         base_q;
	logic                         in_range_q;
	logic                         opening_q;
	logic                         open_q;
	logic                         end_q;
	logic [OIDX_BITS-1:0]         idx_q;

	logic                         valid_s1;
	logic [OIDX_BITS-1:0]         idx_s1;
	logic                         valid_s2;
	logic [OIDX_BITS-1:0]         idx_s2;
	logic signed [PROD_BITS-1:0]  prod_s2;
	logic [ACC_BITS-1:0]          base_s2;

	logic                         strobe_q;
	logic [OIDX_BITS-1:0]         out_idx_q;
	logic [ACC_BITS-1:0]          out_value_q;
	logic                         out_last_q;

	assign weight_we = cmd.load_weight
		&& ({1'b0, weight_index} < (WIDX_BITS + 1)'(WDEPTH));
	assign bias_we = cmd.load_bias
		&& ({1'b0, bias_index} < (OIDX_BITS + 1)'(OUT_COUNT));
	assign weight_raddr = base_q + WIDX_BITS'(idx_q);
	assign sts.idx_last = (idx_q == OIDX_BITS'(OUT_COUNT - 1));

	dlmv_ram #(.WIDTH(VALUE_BITS), .DEPTH(WDEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (weight_we),
		.waddr (weight_index),
		.wdata (operand_value),
		.raddr (weight_raddr),
		.rdata (weight_rd)
	);

	dlmv_ram #(.WIDTH(VALUE_BITS), .DEPTH(OUT_COUNT)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (bias_index),
		.wdata (operand_value),
		.raddr (idx_q),
		.rdata (bias_rd)
	);

	dlmv_ram #(.WIDTH(ACC_BITS), .DEPTH(OUT_COUNT)) u_acc_ram (
		.clk   (clk),
		.we    (valid_s2),
		.waddr (idx_s2),
		.wdata (sum),
		.raddr (idx_q),
		.rdata (acc_rd)
	);

	assign sum = base_s2 + ACC_BITS'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				open_q <= !vector_end;
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2 && end_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q    <= operand_value;
			base_q     <= WIDX_BITS'(input_index * OUT_COUNT);
			in_range_q <= ({1'b0, input_index} < (IIDX_BITS + 1)'(IN_COUNT));
			opening_q  <= !open_q;
			end_q      <= vector_end;
			idx_q      <= '0;
		end else if (cmd.issue) begin
			idx_q <= idx_q + OIDX_BITS'(1);
		end
		idx_s1 <= idx_q;
		idx_s2 <= idx_s1;
		if (in_range_q) begin
			prod_s2 <= value_q * $signed(weight_rd);
		end else begin
			prod_s2 <= '0;
		end
		if (opening_q) begin
			base_s2 <= ACC_BITS'($signed(bias_rd)) << BIAS_SHIFT;
		end else begin
			base_s2 <= acc_rd;
		end
		out_idx_q   <= idx_s2;
		out_value_q <= sum;
		out_last_q  <= (idx_s2 == OIDX_BITS'(OUT_COUNT - 1));
	end

	assign result_strobe = strobe_q;
	assign output_index  = out_idx_q;
	assign output_value  = out_value_q;
	assign output_last   = out_last_q;

endmodule

@@ src/dlmv_chk.sv @@
// ----------------------------------------------------------------------------
// dlmv_chk: port-level checks of the dense layer
// Sequencing of commands and ordering of the result burst, bound to the top.
// ----------------------------------------------------------------------------
module dlmv_chk #(
	parameter int IN_COUNT   = dlmv_pkg::IN_COUNT_DEF,
	parameter int OUT_COUNT  = dlmv_pkg::OUT_COUNT_DEF,
	parameter int VALUE_BITS = dlmv_pkg::VALUE_BITS_DEF,
	localparam int WIDX_BITS = dlmv_pkg::idx_bits(IN_COUNT * OUT_COUNT),
	localparam int OIDX_BITS = dlmv_pkg::idx_bits(OUT_COUNT),
	localparam int IIDX_BITS = dlmv_pkg::idx_bits(IN_COUNT)
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic [1:0]                           op,
	input logic [WIDX_BITS-1:0]                 weight_index,
	input logic [OIDX_BITS-1:0]                 bias_index,
	input logic [IIDX_BITS-1:0]                 input_index,
	input logic signed [VALUE_BITS-1:0]         operand_value,
	input logic                                 vector_end,
	input logic                                 result_strobe,
	input logic [OIDX_BITS-1:0]                 output_index,
	input logic signed [dlmv_pkg::ACC_BITS-1:0] output_value,
	input logic                                 output_last
);
	import dlmv_pkg::*;

	logic data_xfer;
	logic load_xfer;

	assign data_xfer = start && !busy && (op == OP_DATA);
	assign load_xfer = start && !busy && ((op == OP_WEIGHT) || (op == OP_BIAS));

	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		data_xfer |=> busy)
		else $error("data element transfer did not raise busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_xfer |=> !busy)
		else $error("store write raised busy");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && output_last |-> output_index == OIDX_BITS'(OUT_COUNT - 1))
		else $error("last result not at final output position");

	a_burst_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !output_last
			|=> result_strobe
				&& (output_index == $past(output_index) + OIDX_BITS'(1)))
		else $error("result burst broken or out of order");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without a pass in progress");

endmodule

bind dense_layer_matvec_bias dlmv_chk #(
	.IN_COUNT   (IN_COUNT),
	.OUT_COUNT  (OUT_COUNT),
	.VALUE_BITS (VALUE_BITS)
) u_dlmv_chk (.*);
